[design/bu2x_pkg.sv]
// ----------------------------------------------------------------------------
// bu2x_pkg: shared types and constants of the 2x bilinear upscaler
// Field widths, register codes, grid positions and the work item that
// passes from the front part to the back part.
// ----------------------------------------------------------------------------
package bu2x_pkg;

   // default sizes
   localparam int MAX_WIDTH_DEF   = 2048;
   localparam int QUEUE_DEPTH_DEF = 4;
   localparam int MAX_HEIGHT      = 4096;

   // field widths
   localparam int PIX_W       = 8;
   localparam int WIDTH_REG_W = 12;
   localparam int HEIGHT_REG_W = 13;
   localparam int ROW_W       = 12;
   localparam int OUT_ROW_W   = 13;
   localparam int OUT_COL_W   = 12;
   localparam int CSR_DATA_W  = 13;
   localparam int CSR_IDX_W   = 1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT = 1'b1;

   // reset values of the registers
   localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 12'd512;
   localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd512;

   // position inside the 3x3 output patch of one item
   localparam logic [1:0] GRID_LO  = 2'd0;  // row 2i-1 or column 2j-1
   localparam logic [1:0] GRID_MID = 2'd1;  // row 2i or column 2j
   localparam logic [1:0] GRID_HI  = 2'd2;  // row 2i+1 or column 2j+1

   // one classified item waiting for output
   typedef struct packed {
      logic [PIX_W-1:0]     pixel;
      logic [PIX_W-1:0]     h_avg;
      logic [PIX_W-1:0]     v_avg;
      logic [PIX_W-1:0]     d_avg;
      logic [OUT_ROW_W-1:0] orow;
      logic [OUT_COL_W-1:0] ocol;
      logic                 has_above;
      logic                 has_left;
      logic                 last_col;
      logic                 last_row;
   } job_type;

endpackage

[design/bilinear_upscale_2x.sv]
// Streams an 8-bit grey image in raster order and emits the 2x bilinear
// upscaled image with edge replication at the last row and column; each
// result carries its output row and column, and last marks the final
// result of each input pixel. The result port gives one result per clock
// while rsp_ready is high; an input pixel releases one to nine results,
// four for an interior pixel, paced by the single result port of the back
// sequencer. An input pixel passes through the row store read, the queue
// and the output register to its first result. The row store needs no
// clearing after reset; a size register write restarts the frame; the user
// must make it only while the block is idle, which the block does not enforce.
// ----------------------------------------------------------------------------
// bilinear_upscale_2x: 2x bilinear image upscaler, top level
// Front part (intake, row store, averages), item queue and result sequencer.
// ----------------------------------------------------------------------------
module bilinear_upscale_2x #(
   parameter int MAX_WIDTH   = bu2x_pkg::MAX_WIDTH_DEF,
   parameter int QUEUE_DEPTH = bu2x_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [bu2x_pkg::PIX_W-1:0]       req_pixel,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [bu2x_pkg::PIX_W-1:0]       rsp_out_pixel,
   output logic [bu2x_pkg::OUT_ROW_W-1:0]   rsp_out_row,
   output logic [bu2x_pkg::OUT_COL_W-1:0]   rsp_out_col,
   output logic                             rsp_last,
   input  logic                             csr_wr_en,
   input  logic [bu2x_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bu2x_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   logic                               push;
   bu2x_pkg::job_type                  push_job;
   logic                               pop;
   logic                               head_valid;
   bu2x_pkg::job_type                  head_job;
   logic [$clog2(QUEUE_DEPTH+1)-1:0]   q_count;

   // intake and classification
   bu2x_front #(
      .MAX_WIDTH   (MAX_WIDTH),
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_pixel (req_pixel),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .q_count   (q_count),
      .push      (push),
      .push_job  (push_job)
   );

   // items between the two parts
   bu2x_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job),
      .count      (q_count)
   );

   // result sequencing
   bu2x_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head_valid    (head_valid),
      .head_job      (head_job),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_pixel (rsp_out_pixel),
      .rsp_out_row   (rsp_out_row),
      .rsp_out_col   (rsp_out_col),
      .rsp_last      (rsp_last)
   );

endmodule

[design/bu2x_ram.sv]
// ----------------------------------------------------------------------------
// bu2x_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered (read-first).
// ----------------------------------------------------------------------------
module bu2x_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // storage and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[design/bu2x_front.sv]
// ----------------------------------------------------------------------------
// bu2x_front: item intake and classification
// Holds the size registers and the position counters, keeps the previous
// row in a RAM and forms the averages of each item for the back part.
// ----------------------------------------------------------------------------
module bu2x_front #(
   parameter int MAX_WIDTH   = bu2x_pkg::MAX_WIDTH_DEF,
   parameter int QUEUE_DEPTH = bu2x_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [bu2x_pkg::PIX_W-1:0]        req_pixel,
   input  logic                              csr_wr_en,
   input  logic [bu2x_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bu2x_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic [$clog2(QUEUE_DEPTH+1)-1:0]  q_count,
   output logic                              push,
   output bu2x_pkg::job_type                 push_job
);

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int CNT_W  = $clog2(QUEUE_DEPTH+1);
   localparam int WCMP_W = (COL_W + 1 > bu2x_pkg::WIDTH_REG_W) ?
                           COL_W + 1 : bu2x_pkg::WIDTH_REG_W;

   logic [bu2x_pkg::WIDTH_REG_W-1:0]  image_width_ff;
   logic [bu2x_pkg::HEIGHT_REG_W-1:0] image_height_ff;
   logic [COL_W-1:0]                  col_ff;
   logic [bu2x_pkg::ROW_W-1:0]        row_ff;
   logic [bu2x_pkg::PIX_W-1:0]        left_pixel_ff;
   logic [bu2x_pkg::PIX_W-1:0]        left_v_ff;

   logic [WCMP_W-1:0]                 width_ext;
   logic [COL_W-1:0]                  width_m1;
   logic [bu2x_pkg::ROW_W-1:0]        height_m1;
   logic                              accept;
   logic                              last_col_a;
   logic                              last_row_a;
   logic [bu2x_pkg::PIX_W-1:0]        h_avg_a;

   // second stage, aligned with the RAM read data
   logic                              b_valid_ff;
   logic [bu2x_pkg::PIX_W-1:0]        b_pixel_ff;
   logic [bu2x_pkg::PIX_W-1:0]        b_h_avg_ff;
   logic [bu2x_pkg::OUT_ROW_W-1:0]    b_orow_ff;
   logic [bu2x_pkg::OUT_COL_W-1:0]    b_ocol_ff;
   logic                              b_has_above_ff;
   logic                              b_has_left_ff;
   logic                              b_last_col_ff;
   logic                              b_last_row_ff;
   logic [bu2x_pkg::PIX_W-1:0]        above;
   logic [bu2x_pkg::PIX_W-1:0]        v_avg_b;
   logic [bu2x_pkg::PIX_W-1:0]        d_avg_b;

   // effective image size, minus one
   assign width_ext = WCMP_W'(image_width_ff);

   always_comb begin
      if (image_width_ff == '0) begin
         width_m1 = '0;
      end else if (width_ext > WCMP_W'(MAX_WIDTH)) begin
         width_m1 = COL_W'(MAX_WIDTH - 1);
      end else begin
         width_m1 = COL_W'(width_ext - WCMP_W'(1));
      end
   end

   always_comb begin
      if (image_height_ff == '0) begin
         height_m1 = '0;
      end else if (image_height_ff > bu2x_pkg::HEIGHT_REG_W'(bu2x_pkg::MAX_HEIGHT)) begin
         height_m1 = bu2x_pkg::ROW_W'(bu2x_pkg::MAX_HEIGHT - 1);
      end else begin
         height_m1 = bu2x_pkg::ROW_W'(image_height_ff - bu2x_pkg::HEIGHT_REG_W'(1));
      end
   end

   // room for the item counting the one in the second stage
   assign req_ready = ((CNT_W + 1)'(q_count) + (CNT_W + 1)'(b_valid_ff))
                      < (CNT_W + 1)'(QUEUE_DEPTH);
   assign accept    = req_valid && req_ready;

   assign last_col_a = (col_ff == width_m1);
   assign last_row_a = (row_ff == height_m1);
   assign h_avg_a    = bu2x_pkg::PIX_W'(({1'b0, left_pixel_ff} + {1'b0, req_pixel}) >> 1);

   // size registers and position counters
   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= bu2x_pkg::WIDTH_RESET;
         image_height_ff <= bu2x_pkg::HEIGHT_RESET;
         col_ff          <= '0;
         row_ff          <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            bu2x_pkg::CSR_WIDTH: begin
               image_width_ff <= csr_wdata[bu2x_pkg::WIDTH_REG_W-1:0];
            end
            bu2x_pkg::CSR_HEIGHT: begin
               image_height_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         if (last_col_a) begin
            col_ff <= '0;
            row_ff <= last_row_a ? '0 : row_ff + bu2x_pkg::ROW_W'(1);
         end else begin
            col_ff <= col_ff + COL_W'(1);
         end
      end
   end

   // left neighbor, only read when the column is not the first
   always_ff @(posedge clock) begin
      if (accept) begin
         left_pixel_ff <= req_pixel;
      end
   end

   // previous row store: read and write the same column
   bu2x_ram #(
      .WIDTH (bu2x_pkg::PIX_W),
      .DEPTH (MAX_WIDTH)
   ) u_row_store (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (col_ff),
      .wr_data (req_pixel),
      .rd_addr (col_ff),
      .rd_data (above)
   );

   // second stage control
   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= accept;
      end
   end

   // second stage payload
   always_ff @(posedge clock) begin
      if (accept) begin
         b_pixel_ff     <= req_pixel;
         b_h_avg_ff     <= h_avg_a;
         b_orow_ff      <= {row_ff, 1'b0};
         b_ocol_ff      <= bu2x_pkg::OUT_COL_W'({col_ff, 1'b0});
         b_has_above_ff <= (row_ff != '0);
         b_has_left_ff  <= (col_ff != '0);
         b_last_col_ff  <= last_col_a;
         b_last_row_ff  <= last_row_a;
      end
   end

   // vertical and diagonal averages
   assign v_avg_b = bu2x_pkg::PIX_W'(({1'b0, above} + {1'b0, b_pixel_ff}) >> 1);
   assign d_avg_b = bu2x_pkg::PIX_W'(({1'b0, left_v_ff} + {1'b0, v_avg_b}) >> 1);

   always_ff @(posedge clock) begin
      if (b_valid_ff) begin
         left_v_ff <= v_avg_b;
      end
   end

   // hand the item to the queue
   assign push = b_valid_ff;

   always_comb begin
      push_job.pixel     = b_pixel_ff;
      push_job.h_avg     = b_h_avg_ff;
      push_job.v_avg     = v_avg_b;
      push_job.d_avg     = d_avg_b;
      push_job.orow      = b_orow_ff;
      push_job.ocol      = b_ocol_ff;
      push_job.has_above = b_has_above_ff;
      push_job.has_left  = b_has_left_ff;
      push_job.last_col  = b_last_col_ff;
      push_job.last_row  = b_last_row_ff;
   end

   // position stays inside the configured image
   a_pos_in_image: assert property (@(posedge clock) disable iff (reset)
      (col_ff <= width_m1) && (row_ff <= height_m1))
      else $error("front position outside the image");

endmodule

[design/bu2x_queue.sv]
// ----------------------------------------------------------------------------
// bu2x_queue: short queue between front and back
// Register-based FIFO of classified items.
// ----------------------------------------------------------------------------
module bu2x_queue #(
   parameter int DEPTH = bu2x_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  bu2x_pkg::job_type           push_job,
   input  logic                        pop,
   output logic                        head_valid,
   output bu2x_pkg::job_type           head_job,
   output logic [$clog2(DEPTH+1)-1:0]  count
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH+1);

   bu2x_pkg::job_type   entry_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff;
   logic [PTR_W-1:0]    rd_ptr_ff;
   logic [CNT_W-1:0]    count_ff;

   // pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   assign head_valid = (count_ff != '0);
   assign head_job   = entry_ff[rd_ptr_ff];
   assign count      = count_ff;

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (pop || (count_ff < CNT_W'(DEPTH))))
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> (count_ff != '0))
      else $error("queue read while empty");

endmodule

[design/bu2x_back.sv]
// ----------------------------------------------------------------------------
// bu2x_back: result sequencer
// Walks the output patch of the head item one result per cycle unless
// rsp_ready stalls it, in output raster order, into a registered result port.
// ----------------------------------------------------------------------------
module bu2x_back (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             head_valid,
   input  bu2x_pkg::job_type                head_job,
   output logic                             pop,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [bu2x_pkg::PIX_W-1:0]       rsp_out_pixel,
   output logic [bu2x_pkg::OUT_ROW_W-1:0]   rsp_out_row,
   output logic [bu2x_pkg::OUT_COL_W-1:0]   rsp_out_col,
   output logic                             rsp_last
);

   logic [1:0]                      off_r_ff;
   logic [1:0]                      off_c_ff;
   logic                            rsp_valid_ff;
   logic [bu2x_pkg::PIX_W-1:0]      rsp_pixel_ff;
   logic [bu2x_pkg::OUT_ROW_W-1:0]  rsp_row_ff;
   logic [bu2x_pkg::OUT_COL_W-1:0]  rsp_col_ff;
   logic                            rsp_last_ff;

   logic [1:0]                      first_r;
   logic [1:0]                      first_c;
   logic [1:0]                      last_r;
   logic [1:0]                      last_c;
   logic [1:0]                      cur_r;
   logic [1:0]                      cur_c;
   logic                            is_last;
   logic                            load;
   logic [bu2x_pkg::PIX_W-1:0]      val_in;
   logic [bu2x_pkg::OUT_ROW_W-1:0]  row_in;
   logic [bu2x_pkg::OUT_COL_W-1:0]  col_in;

   // patch bounds of the head item
   assign first_r = head_job.has_above ? bu2x_pkg::GRID_LO : bu2x_pkg::GRID_MID;
   assign first_c = head_job.has_left  ? bu2x_pkg::GRID_LO : bu2x_pkg::GRID_MID;
   assign last_r  = head_job.last_row  ? bu2x_pkg::GRID_HI : bu2x_pkg::GRID_MID;
   assign last_c  = head_job.last_col  ? bu2x_pkg::GRID_HI : bu2x_pkg::GRID_MID;
   assign cur_r   = first_r + off_r_ff;
   assign cur_c   = first_c + off_c_ff;
   assign is_last = (cur_r == last_r) && (cur_c == last_c);

   // coordinates of the current result
   always_comb begin
      case (cur_r)
         bu2x_pkg::GRID_LO:  row_in = head_job.orow - bu2x_pkg::OUT_ROW_W'(1);
         bu2x_pkg::GRID_MID: row_in = head_job.orow;
         default:            row_in = head_job.orow | bu2x_pkg::OUT_ROW_W'(1);
      endcase
      case (cur_c)
         bu2x_pkg::GRID_LO:  col_in = head_job.ocol - bu2x_pkg::OUT_COL_W'(1);
         bu2x_pkg::GRID_MID: col_in = head_job.ocol;
         default:            col_in = head_job.ocol | bu2x_pkg::OUT_COL_W'(1);
      endcase
   end

   // value of the current result
   always_comb begin
      if (cur_c == bu2x_pkg::GRID_LO) begin
         val_in = (cur_r == bu2x_pkg::GRID_LO) ? head_job.d_avg : head_job.h_avg;
      end else begin
         val_in = (cur_r == bu2x_pkg::GRID_LO) ? head_job.v_avg : head_job.pixel;
      end
   end

   assign load = head_valid && (!rsp_valid_ff || rsp_ready);
   assign pop  = load && is_last;

   // patch walk
   always_ff @(posedge clock) begin
      if (reset) begin
         off_r_ff <= '0;
         off_c_ff <= '0;
      end else if (load) begin
         if (is_last) begin
            off_r_ff <= '0;
            off_c_ff <= '0;
         end else if (cur_c == last_c) begin
            off_r_ff <= off_r_ff + 2'd1;
            off_c_ff <= '0;
         end else begin
            off_c_ff <= off_c_ff + 2'd1;
         end
      end
   end

   // output register control
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // output register payload
   always_ff @(posedge clock) begin
      if (load) begin
         rsp_pixel_ff <= val_in;
         rsp_row_ff   <= row_in;
         rsp_col_ff   <= col_in;
         rsp_last_ff  <= is_last;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_pixel = rsp_pixel_ff;
   assign rsp_out_row   = rsp_row_ff;
   assign rsp_out_col   = rsp_col_ff;
   assign rsp_last      = rsp_last_ff;

   a_walk_in_patch: assert property (@(posedge clock) disable iff (reset)
      (off_r_ff <= bu2x_pkg::GRID_HI) && (off_c_ff <= bu2x_pkg::GRID_HI))
      else $error("patch walk out of range");

   a_walk_idle_clear: assert property (@(posedge clock) disable iff (reset)
      !head_valid |-> ((off_r_ff == '0) && (off_c_ff == '0)))
      else $error("patch walk left open without an item");

endmodule
